### design/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants of the bilinear image sampler: defaults, codes, reset values.
// ----------------------------------------------------------------------------
package bis_pkg;

    // default configuration of the store and the arithmetic
    localparam int MAX_WIDTH_DEF    = 128;
    localparam int MAX_HEIGHT_DEF   = 128;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 8;

    // request kinds carried in tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // register indexes (word address bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [7:0] DIM_RESET = 8'd128;

endpackage

### design/bis_ram.sv
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-port RAM with registered read and a clock enable.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

### design/bis_place.sv
// ----------------------------------------------------------------------------
// bis_place
// Half-pixel offset, clamp to edge, split into two cell indexes and a weight.
// ----------------------------------------------------------------------------
module bis_place #(
    parameter int MAX_DIM   = 128,
    parameter int FRAC_BITS = 8
) (
    input  logic [15:0]                  raw,
    input  logic [$clog2(MAX_DIM+1)-1:0] dim,
    output logic [$clog2(MAX_DIM)-1:0]   c0,
    output logic [$clog2(MAX_DIM)-1:0]   c1,
    output logic [FRAC_BITS:0]           wt
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = $clog2(MAX_DIM);
    localparam int PW = (16 > DW + FRAC_BITS) ? 16 : DW + FRAC_BITS;

    logic [PW-1:0] raw_ext, half, hi, diff, up, fl, dm1, c0_full;

    always_comb begin
        raw_ext = PW'(raw);
        half    = PW'(1) << (FRAC_BITS - 1);
        hi      = PW'(dim) << FRAC_BITS;
        diff    = raw_ext - half;
        dm1     = PW'(dim) - PW'(1);
        // clamp position to [0, dim]
        priority if (raw_ext < half) begin
            up = '0;
        end else if (diff > hi) begin
            up = hi;
        end else begin
            up = diff;
        end
        fl = up >> FRAC_BITS;
        // floor lands on dim only at the far edge: weight is then one whole cell
        if (fl > dm1) begin
            c0_full = dm1;
            wt      = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else begin
            c0_full = fl;
            wt      = {1'b0, up[FRAC_BITS-1:0]};
        end
        c0 = c0_full[CW-1:0];
        c1 = (c0_full == dm1) ? c0_full[CW-1:0] : c0_full[CW-1:0] + CW'(1);
    end

endmodule

### design/bis_lerp.sv
// ----------------------------------------------------------------------------
// bis_lerp
// Two-stage bilinear blend of one channel: along y, then along x, rounded.
// ----------------------------------------------------------------------------
module bis_lerp #(
    parameter int CHANNEL_BITS = 16,
    parameter int FRAC_BITS    = 8
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [CHANNEL_BITS-1:0] t00,
    input  logic [CHANNEL_BITS-1:0] t01,
    input  logic [CHANNEL_BITS-1:0] t10,
    input  logic [CHANNEL_BITS-1:0] t11,
    input  logic [FRAC_BITS:0]      xf,
    input  logic [FRAC_BITS:0]      yf,
    output logic [CHANNEL_BITS-1:0] result
);

    localparam int AW = CHANNEL_BITS + FRAC_BITS + 1;
    localparam int VW = CHANNEL_BITS + 2 * FRAC_BITS + 2;

    logic [FRAC_BITS:0] one_w, omy, omx;
    logic [AW-1:0]      a_next, b_next, a_reg, b_reg;
    logic [FRAC_BITS:0] xf_reg;
    logic [VW-1:0]      v;

    // stage 1: blend along y
    always_comb begin
        one_w  = (FRAC_BITS+1)'(1) << FRAC_BITS;
        omy    = one_w - yf;
        a_next = AW'(t00) * AW'(omy) + AW'(t01) * AW'(yf);
        b_next = AW'(t10) * AW'(omy) + AW'(t11) * AW'(yf);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            xf_reg <= xf;
        end
    end

    // stage 2: blend along x, round half up
    always_comb begin
        omx = one_w - xf_reg;
        v   = VW'(a_reg) * VW'(omx) + VW'(b_reg) * VW'(xf_reg)
            + (VW'(1) << (2 * FRAC_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result <= v[2*FRAC_BITS+CHANNEL_BITS-1:2*FRAC_BITS];
        end
    end

endmodule

### design/bilinear_image_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_image_sampler
// Four-channel image store with clamp-to-edge bilinear sampling.
//
//   channel   dir  contents
//   s_axis    in   tuser: req_type; tdata: write/sample request
//   m_axis    out  tdata: rounded channels of one sample
//   apb       in   image_width at 0x0, image_height at 0x4
//
// One request per cycle sustained while m_axis does not stall. The store is
// split into four banks by column and row parity so the four texels come
// out of one read per bank in the same cycle.
// Writes and samples share one pipeline, so a sample sees every earlier write.
// A stall on m_axis holds the whole pipeline; s_tready follows at once.
// Reset clears valids and sets both sizes to 128; the store is undefined until written.
// ----------------------------------------------------------------------------
module bilinear_image_sampler
    import bis_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = MAX_HEIGHT_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // col[6:0] row[13:7] red[29:14] green[45:30] blue[61:46] alpha[77:62]
    // sample_x[93:78] sample_y[109:94], zero pad [111:110]
    input  logic [111:0] s_tdata,
    // req_type[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // red[15:0] green[31:16] blue[47:32] alpha[63:48]
    output logic [63:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int DW     = $clog2(MAX_WIDTH + 1);
    localparam int DH     = $clog2(MAX_HEIGHT + 1);
    localparam int CWX    = $clog2(MAX_WIDTH);
    localparam int CWY    = $clog2(MAX_HEIGHT);
    localparam int HALF_W = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
    localparam int BDEPTH = HALF_W * HALF_H;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int PXW    = 4 * CHANNEL_BITS;

    // ---------------- configuration ----------------
    logic [7:0] width_reg, height_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[7:0];
                REG_HEIGHT: height_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {24'd0, width_reg};
            REG_HEIGHT: prdata = {24'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    // dimensions saturated to [1, MAX]
    logic [15:0]   w_ext, h_ext;
    logic [DW-1:0] dim_w;
    logic [DH-1:0] dim_h;

    always_comb begin
        w_ext = 16'(width_reg);
        h_ext = 16'(height_reg);
        priority if (w_ext == 16'd0)      dim_w = DW'(1);
        else if (w_ext > 16'(MAX_WIDTH))  dim_w = DW'(MAX_WIDTH);
        else                              dim_w = w_ext[DW-1:0];
        priority if (h_ext == 16'd0)      dim_h = DH'(1);
        else if (h_ext > 16'(MAX_HEIGHT)) dim_h = DH'(MAX_HEIGHT);
        else                              dim_h = h_ext[DH-1:0];
    end

    // ---------------- pipeline advance ----------------
    logic adv;
    logic m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    // ---------------- stage 1: request capture ----------------
    logic         v1_reg;
    logic [111:0] d1_reg;
    logic         t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg <= s_tdata;
            t1_reg <= s_tuser[0];
        end
    end

    // ---------------- stage 2: place and bank addressing ----------------
    logic [CWX-1:0]     x0, x1;
    logic [CWY-1:0]     y0, y1;
    logic [FRAC_BITS:0] xf, yf;

    bis_place #(.MAX_DIM(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_place_x (
        .raw(d1_reg[93:78]), .dim(dim_w), .c0(x0), .c1(x1), .wt(xf)
    );

    bis_place #(.MAX_DIM(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_place_y (
        .raw(d1_reg[109:94]), .dim(dim_h), .c0(y0), .c1(y1), .wt(yf)
    );

    logic [15:0]    col16, row16;
    logic           in_range;
    logic [1:0]     wbank;
    logic [BAW-1:0] waddr;
    logic [BAW-1:0] addr_next [4];
    logic [3:0]     we_next;
    logic [PXW-1:0] wdata_next;
    int             cx, ry;

    always_comb begin
        col16    = 16'(d1_reg[6:0]);
        row16    = 16'(d1_reg[13:7]);
        in_range = (col16 < 16'(MAX_WIDTH)) && (row16 < 16'(MAX_HEIGHT));
        wbank    = {row16[0], col16[0]};
        waddr    = BAW'(int'(row16 >> 1) * HALF_W + int'(col16 >> 1));
        for (int c = 0; c < 4; c++) begin
            wdata_next[c*CHANNEL_BITS +: CHANNEL_BITS] =
                d1_reg[14 + 16*c +: CHANNEL_BITS];
        end
        // bank {row parity, column parity}: pick whichever of the pair matches
        for (int b = 0; b < 4; b++) begin
            cx = (x0[0] == b[0]) ? (int'(x0) >> 1) : (int'(x1) >> 1);
            ry = (y0[0] == b[1]) ? (int'(y0) >> 1) : (int'(y1) >> 1);
            addr_next[b] = (t1_reg == REQ_SAMPLE) ? BAW'(ry * HALF_W + cx) : waddr;
            we_next[b]   = v1_reg && (t1_reg == REQ_WRITE) && in_range
                           && (wbank == 2'(b));
        end
    end

    logic               v2_reg;
    logic [BAW-1:0]     addr2_reg [4];
    logic [3:0]         we2_reg;
    logic [PXW-1:0]     wdata2_reg;
    logic [3:0]         par2_reg;   // x0, x1, y0, y1 parity
    logic [FRAC_BITS:0] xf2_reg, yf2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg  <= 1'b0;
            we2_reg <= '0;
        end else if (adv) begin
            v2_reg  <= v1_reg && (t1_reg == REQ_SAMPLE);
            we2_reg <= we_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            addr2_reg  <= addr_next;
            wdata2_reg <= wdata_next;
            par2_reg   <= {y1[0], y0[0], x1[0], x0[0]};
            xf2_reg    <= xf;
            yf2_reg    <= yf;
        end
    end

    // ---------------- stage 3: banked store ----------------
    logic [PXW-1:0] rd [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        bis_ram #(.WIDTH(PXW), .DEPTH(BDEPTH)) u_ram (
            .aclk(aclk), .en(adv), .we(we2_reg[b]), .addr(addr2_reg[b]),
            .wdata(wdata2_reg), .rdata(rd[b])
        );
    end

    logic               v3_reg;
    logic [3:0]         par3_reg;
    logic [FRAC_BITS:0] xf3_reg, yf3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            par3_reg <= par2_reg;
            xf3_reg  <= xf2_reg;
            yf3_reg  <= yf2_reg;
        end
    end

    // texel selection by parity
    logic [PXW-1:0] p00, p01, p10, p11;

    always_comb begin
        p00 = rd[{par3_reg[2], par3_reg[0]}];
        p01 = rd[{par3_reg[3], par3_reg[0]}];
        p10 = rd[{par3_reg[2], par3_reg[1]}];
        p11 = rd[{par3_reg[3], par3_reg[1]}];
    end

    // ---------------- stages 4-5: interpolation ----------------
    logic [CHANNEL_BITS-1:0] chan [4];

    for (genvar c = 0; c < 4; c++) begin : g_chan
        bis_lerp #(.CHANNEL_BITS(CHANNEL_BITS), .FRAC_BITS(FRAC_BITS)) u_lerp (
            .aclk(aclk), .en(adv),
            .t00(p00[c*CHANNEL_BITS +: CHANNEL_BITS]),
            .t01(p01[c*CHANNEL_BITS +: CHANNEL_BITS]),
            .t10(p10[c*CHANNEL_BITS +: CHANNEL_BITS]),
            .t11(p11[c*CHANNEL_BITS +: CHANNEL_BITS]),
            .xf(xf3_reg), .yf(yf3_reg), .result(chan[c])
        );
        assign m_tdata[16*c +: 16] = 16'(chan[c]);
    end

    logic v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

endmodule

### design/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bis_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [111:0] s_tdata,
    input logic [0:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    // pipeline takes requests whenever the output slot is free or drains
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output slot");

    // a held result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("pready low");

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (.*);

### sim/tb_bilinear_image_sampler.sv
// ----------------------------------------------------------------------------
// tb_bilinear_image_sampler
// Self-checking bench for the bilinear image sampler: pixel writes build an
// image, samples are predicted by a local clamp-to-edge bilinear model and
// compared channel by channel on m_axis under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_bilinear_image_sampler;
    import bis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW      = MAX_WIDTH_DEF;
    localparam int MAXH      = MAX_HEIGHT_DEF;
    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int ONE       = 1 << FRAC;
    localparam int LATENCY   = 5;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } texel_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predictor state
    texel_t     image_mem [MAXW*MAXH];
    bit         written   [MAXW*MAXH];
    int         cur_width;
    int         cur_height;
    texel_t     expected_samples [$];
    int         error_count;
    int         idle_cycles;
    bit         no_idle;
    int         sink_hold;

    bilinear_image_sampler u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // request: {sample_y, sample_x, alpha, blue, green, red, row, col}
    function automatic logic [111:0] pack_request(int col, int row, texel_t px,
                                                  int sx, int sy);
        return {2'b00, sy[15:0], sx[15:0], px.alpha, px.blue, px.green, px.red,
                row[6:0], col[6:0]};
    endfunction

    // clamp a position to the image and split into cells and weight
    function automatic void locate(int raw, int dim, output int c0, output int c1,
                                   output int wt);
        int p;
        p = raw - ONE/2;
        if (p < 0) p = 0;
        if (p > dim*ONE) p = dim*ONE;
        c0 = p >> FRAC;
        if (c0 > dim-1) c0 = dim-1;
        c1 = (c0+1 > dim-1) ? dim-1 : c0+1;
        wt = p - (c0 << FRAC);
    endfunction

    function automatic int eff_dim(int v, int mx);
        if (v < 1) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic texel_t interpolate(int sx, int sy);
        int x0, x1, y0, y1, xf, yf, w, h;
        longint a, b, v;
        texel_t t00, t01, t10, t11, res;
        w = eff_dim(cur_width, MAXW);
        h = eff_dim(cur_height, MAXH);
        locate(sx, w, x0, x1, xf);
        locate(sy, h, y0, y1, yf);
        t00 = image_mem[y0*MAXW+x0];
        t01 = image_mem[y1*MAXW+x0];
        t10 = image_mem[y0*MAXW+x1];
        t11 = image_mem[y1*MAXW+x1];
        for (int ch = 0; ch < 4; ch++) begin
            a = longint'(t00[ch*16 +: 16])*(ONE-yf) + longint'(t01[ch*16 +: 16])*yf;
            b = longint'(t10[ch*16 +: 16])*(ONE-yf) + longint'(t11[ch*16 +: 16])*yf;
            v = a*(ONE-xf) + b*xf;
            res[ch*16 +: 16] = 16'((v + (1 << (2*FRAC-1))) >> (2*FRAC));
        end
        return res;
    endfunction

    // send one request, idling at random beforehand
    task automatic send_request(logic kind, int col, int row, texel_t px,
                                int sx, int sy);
        while (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pack_request(col, row, px, sx, sy);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == REQ_WRITE) begin
            image_mem[row*MAXW+col] = px;
            written[row*MAXW+col]   = 1'b1;
        end else begin
            // the port carries 16 position bits
            expected_samples.push_back(interpolate(sx & 16'hFFFF, sy & 16'hFFFF));
        end
    endtask

    task automatic write_pixel(int col, int row, texel_t px);
        send_request(REQ_WRITE, col, row, px, 0, 0);
    endtask

    task automatic sample_at(int sx, int sy);
        send_request(REQ_SAMPLE, 0, 0, texel_t'(0), sx, sy);
    endtask

    function automatic texel_t random_texel();
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic apb_write(logic reg_idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_WIDTH) cur_width = value & 8'hFF;
        else cur_height = value & 8'hFF;
    endtask

    task automatic set_size(int w, int h);
        drain();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
    endtask

    // fill the whole active area so no sample reads an unwritten texel
    task automatic fill_image(int w, int h);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (!written[r*MAXW+c] || $urandom_range(3) == 0)
                    write_pixel(c, r, random_texel());
    endtask

    // random position biased toward edges and in-range values
    function automatic int random_pos(int dim);
        case ($urandom_range(4))
            0: return $urandom_range(ONE);
            1: return dim*ONE - ONE/2 + $urandom_range(ONE) ;
            2: return $urandom_range(16'hFFFF);
            default: return $urandom_range(dim*ONE + ONE);
        endcase
    endfunction

    // extremes of fields on a small image
    task automatic test_directed();
        set_size(2, 2);
        write_pixel(0, 0, {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        write_pixel(1, 0, {16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF});
        write_pixel(0, 1, {16'h8000, 16'h7FFF, 16'h0000, 16'h1234});
        write_pixel(1, 1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        sample_at(0, 0);
        sample_at(16'hFFFF, 16'hFFFF);
        sample_at(ONE, ONE);
        sample_at(ONE/2, ONE/2);
        sample_at(ONE/2 + 1, ONE + ONE/2 - 1);
        sample_at(ONE/2 + ONE/2, ONE/2 + 3*ONE/4);
        sample_at(2*ONE, 0);
        sample_at(0, 16'hFFFF);
        // far corner of the store, outside the active area
        write_pixel(127, 127, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        write_pixel(127, 0, random_texel());
        write_pixel(0, 127, random_texel());
        sample_at(16'h1234, 16'h00C0);
    endtask

    // zero register treated as one, one-pixel image
    task automatic test_degenerate_size();
        set_size(0, 0);
        sample_at($urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        sample_at(0, 0);
        set_size(1, 2);
        sample_at(ONE, ONE);
        sample_at(16'hFFFF, ONE);
    endtask

    // random writes and samples, changing image size between phases
    task automatic test_random(int count, int w, int h);
        set_size(w, h);
        fill_image(eff_dim(w, MAXW), eff_dim(h, MAXH));
        for (int i = 0; i < count; i++) begin
            int ew, eh;
            ew = eff_dim(w, MAXW);
            eh = eff_dim(h, MAXH);
            if ($urandom_range(3) == 0)
                write_pixel($urandom_range(127), $urandom_range(127) % eh,
                            random_texel());
            else if ($urandom_range(9) == 0)
                write_pixel($urandom_range(ew-1), $urandom_range(127), random_texel());
            else
                sample_at(random_pos(ew), random_pos(eh));
        end
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        sink_hold = 200;
        for (int i = 0; i < 60; i++)
            sample_at(random_pos(cur_width), random_pos(cur_height));
        drain();
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                error_count++;
            end else begin
                texel_t exp_t;
                exp_t = expected_samples.pop_front();
                for (int ch = 0; ch < 4; ch++)
                    if (exp_t[ch*16 +: 16] !== m_tdata[ch*16 +: 16]) begin
                        $display("%0t: channel %0d expected %h actual %h",
                                 $realtime, ch, exp_t[ch*16 +: 16],
                                 m_tdata[ch*16 +: 16]);
                        error_count++;
                    end
            end
        end
    end

    // receiver idling and long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        sink_hold = 0;
        cur_width = DIM_RESET;
        cur_height = DIM_RESET;
        for (int i = 0; i < MAXW*MAXH; i++) written[i] = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_degenerate_size();
        test_random(200, 3, 5);
        test_backpressure();
        no_idle = 1'b1;
        test_random(250, 7, 1);
        no_idle = 1'b0;
        test_random(200, 16, 9);
        // width register above the store saturates; short image keeps fill small
        test_random(150, 255, 2);
        test_backpressure();
        drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
